// ===== hdl/dta_pkg.sv =====
package dta_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 16;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_DEBOUNCE_TICKS = 2'd0,
        REG_THRESHOLD_STEP = 2'd1,
        REG_THRESHOLD_MAX  = 2'd2
    } cfg_reg_t;

    localparam logic [15:0] DEBOUNCE_TICKS_RESET = 16'd50;
    localparam logic [9:0]  THRESHOLD_STEP_RESET = 10'd10;
    localparam logic [15:0] THRESHOLD_MAX_RESET  = 16'd10000;
    localparam logic [15:0] THRESHOLD_RESET      = 16'd50;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BOUNCE = 3'd1,
        PH_HELD   = 3'd2,
        PH_FALL   = 3'd3,
        PH_RISE   = 3'd4
    } key_phase_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_ALARM   = 2'd1,
        MODE_PASSIVE = 2'd2
    } mode_t;

    typedef struct packed {
        logic        alarm_key_level;
        logic        raise_key_level;
        logic        lower_key_level;
        logic [15:0] measurement;
    } sample_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic        alarm_active;
        logic        alarm_switched;
        logic [15:0] threshold_now;
        logic        threshold_changed;
        logic        request_refused;
    } result_t;

    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [9:0]  threshold_step;
        logic [15:0] threshold_max;
    } settings_t;

    typedef struct packed {
        logic alarm;
        logic raise;
        logic lower;
    } key_events_t;

endpackage

// ===== hdl/debounced_threshold_alarm_ctrl.sv =====
// Debounced threshold alarm controller. Each sample transfer is one tick: three
// raw active-low key levels are debounced into press events, which drive a
// normal/alarm/passive mode machine and step the alarm threshold. One result
// transfer leaves for every sample transfer, once the sample has passed the
// input register, then the result register. A sample can be taken every
// cycle while the result side does not stall; the single pass through the
// debouncers and the mode machine sets that rate. Registers: 0 debounce_ticks,
// 1 threshold_step, 2 threshold_max; write them only while no sample is in flight.
module debounced_threshold_alarm_ctrl #(
    parameter int COUNT_WIDTH = dta_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  dta_pkg::sample_t                     sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output dta_pkg::result_t                     result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dta_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [dta_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import dta_pkg::*;

    settings_t   settings_reg;
    logic        hold_valid_reg;
    sample_t     hold_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    logic        out_ready, advance, accept;
    key_events_t events;
    result_t     result_calc;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings_reg.debounce_ticks <= DEBOUNCE_TICKS_RESET;
            settings_reg.threshold_step <= THRESHOLD_STEP_RESET;
            settings_reg.threshold_max  <= THRESHOLD_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE_TICKS: settings_reg.debounce_ticks <= cfg_data[15:0];
                REG_THRESHOLD_STEP: settings_reg.threshold_step <= cfg_data[9:0];
                REG_THRESHOLD_MAX:  settings_reg.threshold_max  <= cfg_data[15:0];
                default:            settings_reg <= settings_reg;
            endcase
        end
    end

    // two-register pipe, each stage moves when the one after it frees up
    assign out_ready    = !out_valid_reg || !result_stall;
    assign advance      = hold_valid_reg && out_ready;
    assign sample_stall = hold_valid_reg && !out_ready;
    assign accept       = sample_valid && !sample_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                hold_valid_reg <= 1'b1;
            else if (advance)
                hold_valid_reg <= 1'b0;
            if (out_ready)
                out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_reg <= sample;
        if (advance)
            out_reg <= result_calc;
    end

    dta_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_alarm_key (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .level          (hold_reg.alarm_key_level),
        .debounce_ticks (settings_reg.debounce_ticks),
        .press          (events.alarm)
    );

    dta_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_raise_key (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .level          (hold_reg.raise_key_level),
        .debounce_ticks (settings_reg.debounce_ticks),
        .press          (events.raise)
    );

    dta_debounce #(.COUNT_WIDTH(COUNT_WIDTH)) u_lower_key (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (advance),
        .level          (hold_reg.lower_key_level),
        .debounce_ticks (settings_reg.debounce_ticks),
        .press          (events.lower)
    );

    dta_mode_ctrl u_mode_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .events      (events),
        .measurement (hold_reg.measurement),
        .settings    (settings_reg),
        .result      (result_calc)
    );

endmodule

// ===== hdl/dta_debounce.sv =====
module dta_debounce #(
    parameter int COUNT_WIDTH = dta_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        level,
    input  logic [15:0] debounce_ticks,
    output logic        press
);
    import dta_pkg::*;

    localparam int CMP_WIDTH = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    key_phase_t             phase_reg, phase_next;
    logic                   last_reg, last_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [CMP_WIDTH-1:0]   ticks_ext, max_ext, target, count_ext;
    logic                   low;

    assign low       = ~level;
    assign count_inc = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign ticks_ext = CMP_WIDTH'(debounce_ticks);
    assign max_ext   = CMP_WIDTH'(COUNT_MAX);
    assign target    = (ticks_ext > max_ext) ? max_ext : ticks_ext;
    assign count_ext = CMP_WIDTH'(count_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            last_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (en)
        begin
            phase_reg <= phase_next;
            last_reg  <= last_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        last_next  = last_reg;
        count_next = count_reg;
        case (phase_reg)
            PH_BOUNCE:
            begin
                count_next = count_inc;
                if (count_ext >= target)
                begin
                    if (low && !last_reg)
                        phase_next = PH_FALL;
                    else if (!low && last_reg)
                        phase_next = PH_RISE;
                    else
                        phase_next = last_reg ? PH_HELD : PH_IDLE;
                end
            end
            PH_FALL:
            begin
                if (low)
                    phase_next = PH_HELD;
                else
                begin
                    phase_next = PH_BOUNCE;
                    last_next  = 1'b1;
                    count_next = '0;
                end
            end
            PH_HELD:
            begin
                if (!low)
                begin
                    phase_next = PH_BOUNCE;
                    last_next  = 1'b1;
                    count_next = '0;
                end
            end
            PH_RISE:
            begin
                if (!low)
                    phase_next = PH_IDLE;
                else
                begin
                    phase_next = PH_BOUNCE;
                    last_next  = 1'b0;
                    count_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (low)
                begin
                    phase_next = PH_BOUNCE;
                    last_next  = 1'b0;
                    count_next = '0;
                end
            end
        endcase
    end

    assign press = (phase_next == PH_FALL);

endmodule

// ===== hdl/dta_mode_ctrl.sv =====
module dta_mode_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  dta_pkg::key_events_t  events,
    input  logic [15:0]           measurement,
    input  dta_pkg::settings_t    settings,
    output dta_pkg::result_t      result
);
    import dta_pkg::*;

    mode_t       mode_reg, mode_next;
    logic        drive_reg, drive_next;
    logic [15:0] thr_reg, thr_next;
    mode_t       mode_cur;
    logic        do_raise, do_lower, refused;
    logic [16:0] thr_sum;
    logic [15:0] step_ext;

    assign step_ext = 16'(settings.threshold_step);
    assign thr_sum  = {1'b0, thr_reg} + {1'b0, step_ext};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NORMAL;
            drive_reg <= 1'b0;
            thr_reg   <= THRESHOLD_RESET;
        end
        else if (en)
        begin
            mode_reg  <= mode_next;
            drive_reg <= drive_next;
            thr_reg   <= thr_next;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_ALARM:   mode_cur = MODE_ALARM;
            MODE_PASSIVE: mode_cur = MODE_PASSIVE;
            default:      mode_cur = MODE_NORMAL;
        endcase
        if (events.alarm)
            mode_cur = (mode_cur == MODE_PASSIVE) ? MODE_NORMAL : MODE_PASSIVE;

        refused  = 1'b0;
        do_raise = 1'b0;
        do_lower = 1'b0;
        if (events.raise)
        begin
            if (mode_cur == MODE_ALARM)
                refused = 1'b1;
            else
                do_raise = 1'b1;
        end
        if (events.lower && !do_raise)
        begin
            if (mode_cur == MODE_ALARM)
                refused = 1'b1;
            else
                do_lower = 1'b1;
        end

        mode_next  = mode_cur;
        thr_next   = thr_reg;
        drive_next = 1'b0;
        if (do_raise)
            thr_next = (thr_sum > {1'b0, settings.threshold_max})
                       ? settings.threshold_max : thr_sum[15:0];
        else if (do_lower)
            thr_next = (thr_reg < step_ext) ? '0 : thr_reg - step_ext;
        else if (mode_cur == MODE_NORMAL)
        begin
            if (measurement >= thr_reg)
                mode_next = MODE_ALARM;
        end
        else if (mode_cur == MODE_ALARM)
        begin
            drive_next = 1'b1;
            if (measurement < thr_reg)
                mode_next = MODE_NORMAL;
        end

        result.mode              = mode_next;
        result.alarm_active      = drive_next;
        result.alarm_switched    = drive_next != drive_reg;
        result.threshold_now     = thr_next;
        result.threshold_changed = thr_next != thr_reg;
        result.request_refused   = refused;
    end

endmodule

// ===== tb/debounced_threshold_alarm_ctrl_tb.sv =====
`timescale 1ns / 100ps

module debounced_threshold_alarm_ctrl_tb;
    import dta_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    class alarm_scoreboard;
        logic [15:0] debounce_ticks;
        logic [9:0]  threshold_step;
        logic [15:0] threshold_max;
        key_phase_t  phase [3];
        bit          stable [3];
        logic [15:0] settle [3];
        mode_t       mode_now;
        bit          drive;
        logic [15:0] threshold;
        result_t     expected_results [$];
        int          mismatches;

        function new();
            debounce_ticks = DEBOUNCE_TICKS_RESET;
            threshold_step = THRESHOLD_STEP_RESET;
            threshold_max = THRESHOLD_MAX_RESET;
            for (int k = 0; k < 3; k++)
            begin
                phase[k] = PH_IDLE;
                stable[k] = 1'b0;
                settle[k] = '0;
            end
            mode_now = MODE_NORMAL;
            drive = 1'b0;
            threshold = THRESHOLD_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [15:0] value);
            case (idx)
                REG_DEBOUNCE_TICKS: debounce_ticks = value;
                REG_THRESHOLD_STEP: threshold_step = value[9:0];
                REG_THRESHOLD_MAX:  threshold_max = value;
                default: ;
            endcase
        endfunction

        function void start_bounce(int k, bit from_pressed);
            stable[k] = from_pressed;
            phase[k] = PH_BOUNCE;
            settle[k] = '0;
        endfunction

        // one debouncer tick, returns 1 on a press
        function bit key_press(int k, logic level);
            bit is_low;
            is_low = (level == 1'b0);
            case (phase[k])
                PH_BOUNCE:
                begin
                    if (settle[k] != 16'hFFFF)
                        settle[k] = settle[k] + 16'd1;
                    if (settle[k] >= debounce_ticks)
                    begin
                        if (is_low && !stable[k])
                            phase[k] = PH_FALL;
                        else if (!is_low && stable[k])
                            phase[k] = PH_RISE;
                        else if (stable[k])
                            phase[k] = PH_HELD;
                        else
                            phase[k] = PH_IDLE;
                    end
                end
                PH_FALL:
                begin
                    if (is_low)
                        phase[k] = PH_HELD;
                    else
                        start_bounce(k, 1'b1);
                end
                PH_HELD:
                begin
                    if (!is_low)
                        start_bounce(k, 1'b1);
                end
                PH_RISE:
                begin
                    if (!is_low)
                        phase[k] = PH_IDLE;
                    else
                        start_bounce(k, 1'b0);
                end
                default:
                begin
                    phase[k] = PH_IDLE;
                    if (is_low)
                        start_bounce(k, 1'b0);
                end
            endcase
            return phase[k] == PH_FALL;
        endfunction

        function void note_sample(sample_t s);
            bit          ev_alarm;
            bit          ev_raise;
            bit          ev_lower;
            bit          refused;
            bit          old_drive;
            int          step_dir;
            mode_t       m;
            logic [15:0] old_thr;
            logic [16:0] sum;
            result_t     r;
            ev_alarm = key_press(0, s.alarm_key_level);
            ev_raise = key_press(1, s.raise_key_level);
            ev_lower = key_press(2, s.lower_key_level);
            m = mode_now;
            old_drive = drive;
            old_thr = threshold;
            refused = 1'b0;
            step_dir = 0;
            if (ev_alarm)
            begin
                if (m == MODE_PASSIVE)
                    m = MODE_NORMAL;
                else
                    m = MODE_PASSIVE;
            end
            if (ev_raise)
            begin
                if (m == MODE_ALARM)
                    refused = 1'b1;
                else
                    step_dir = 1;
            end
            if (ev_lower && step_dir == 0)
            begin
                if (m == MODE_ALARM)
                    refused = 1'b1;
                else
                    step_dir = -1;
            end
            if (step_dir > 0)
            begin
                sum = {1'b0, threshold} + threshold_step;
                if (sum > threshold_max)
                    sum = {1'b0, threshold_max};
                threshold = sum[15:0];
                drive = 1'b0;
            end
            else if (step_dir < 0)
            begin
                if (threshold < threshold_step)
                    threshold = '0;
                else
                    threshold = threshold - threshold_step;
                drive = 1'b0;
            end
            else if (m == MODE_NORMAL)
            begin
                drive = 1'b0;
                if (s.measurement >= threshold)
                    m = MODE_ALARM;
            end
            else if (m == MODE_ALARM)
            begin
                drive = 1'b1;
                if (s.measurement < threshold)
                    m = MODE_NORMAL;
            end
            else
                drive = 1'b0;
            mode_now = m;
            r.mode = m;
            r.alarm_active = drive;
            r.alarm_switched = (drive != old_drive);
            r.threshold_now = threshold;
            r.threshold_changed = (threshold != old_thr);
            r.request_refused = refused;
            expected_results.push_back(r);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing expected: %h", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.mode !== want.mode || got.alarm_active !== want.alarm_active
                || got.alarm_switched !== want.alarm_switched
                || got.threshold_now !== want.threshold_now
                || got.threshold_changed !== want.threshold_changed
                || got.request_refused !== want.request_refused)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $write("result mismatch (expected/actual): mode %0d/%0d active %0b/%0b",
                           want.mode, got.mode, want.alarm_active, got.alarm_active);
                    $write(" switched %0b/%0b threshold %0d/%0d",
                           want.alarm_switched, got.alarm_switched,
                           want.threshold_now, got.threshold_now);
                    $display(" changed %0b/%0b refused %0b/%0b",
                             want.threshold_changed, got.threshold_changed,
                             want.request_refused, got.request_refused);
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        sample_valid = 1'b0;
    sample_t     sample = '0;
    logic        result_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic        sample_stall;
    logic        result_valid;
    result_t     result;
    logic        cfg_ready;

    alarm_scoreboard sb;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    int quiet_cycles = 0;
    int run_left [3];
    bit run_level [3];

    debounced_threshold_alarm_ctrl u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.check_result(result);
            if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
                || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [15:0] ticks, logic [9:0] stepv, logic [15:0] maxv);
        write_reg(REG_DEBOUNCE_TICKS, ticks);
        write_reg(REG_THRESHOLD_STEP, {6'd0, stepv});
        write_reg(REG_THRESHOLD_MAX, maxv);
    endtask

    task automatic send_sample(sample_t s);
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        sb.note_sample(s);
        if ($urandom_range(99) < idle_pct)
        begin
            sample_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    // wait until every expected result transfer has arrived
    task automatic drain();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_results.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic tick(bit alarm_lvl, bit raise_lvl, bit lower_lvl, logic [15:0] meas);
        sample_t s;
        s.alarm_key_level = alarm_lvl;
        s.raise_key_level = raise_lvl;
        s.lower_key_level = lower_lvl;
        s.measurement = meas;
        send_sample(s);
    endtask

    // two ticks low, two ticks released; enough with zero debounce
    task automatic press(bit alarm_k, bit raise_k, bit lower_k, logic [15:0] meas);
        repeat (2) tick(!alarm_k, !raise_k, !lower_k, meas);
        repeat (2) tick(1'b1, 1'b1, 1'b1, meas);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        int      t;
        bit      lvl [3];
        for (int k = 0; k < 3; k++)
        begin
            if (run_left[k] == 0)
            begin
                run_level[k] = !run_level[k];
                if ($urandom_range(3) == 0)
                    run_left[k] = $urandom_range(2, 1);
                else if (sb.debounce_ticks > 20)
                    run_left[k] = $urandom_range(30, 1);
                else
                    run_left[k] = sb.debounce_ticks + $urandom_range(8, 2);
                if (k == 0 && run_level[k])
                    run_left[k] = run_left[k] * 3;
            end
            run_left[k]--;
            lvl[k] = run_level[k];
        end
        s.alarm_key_level = lvl[0];
        s.raise_key_level = lvl[1];
        s.lower_key_level = lvl[2];
        case ($urandom_range(9))
            0: s.measurement = 16'd0;
            1: s.measurement = 16'hFFFF;
            2, 3: s.measurement = 16'($urandom_range(16'hFFFF));
            default:
            begin
                t = int'(sb.threshold) + int'($urandom_range(4)) - 2;
                if (t < 0)
                    t = 0;
                if (t > 65535)
                    t = 65535;
                s.measurement = t[15:0];
            end
        endcase
        return s;
    endfunction

    task automatic run_phase(int n, int idle_p, int stall_p);
        idle_pct = idle_p;
        stall_pct = stall_p;
        repeat (n) send_sample(random_sample());
        drain();
    endtask

    initial
    begin
        sb = new();
        for (int k = 0; k < 3; k++)
        begin
            run_left[k] = 0;
            run_level[k] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero debounce, large step, low ceiling
        configure(16'd0, 10'd1000, 16'd1500);
        tick(1'b1, 1'b1, 1'b1, 16'd0);
        press(1'b0, 1'b1, 1'b0, 16'd0);
        press(1'b0, 1'b1, 1'b0, 16'd0);
        press(1'b0, 1'b1, 1'b1, 16'd0);
        press(1'b0, 1'b0, 1'b1, 16'd0);
        press(1'b0, 1'b0, 1'b1, 16'd0);
        press(1'b0, 1'b1, 1'b0, 16'hFFFF);
        press(1'b1, 1'b0, 1'b0, 16'hFFFF);
        drain();

        configure(16'd1, 10'd1, 16'hFFFF);
        run_phase(250, 0, 0);
        configure(16'd3, 10'd37, 16'd300);
        run_phase(250, 61, 0);
        configure(16'd2, 10'd1000, 16'hFFFF);
        run_phase(250, 0, 61);
        configure(16'd5, 10'd250, 16'd1);
        run_phase(250, 32, 32);

        // long receiver hold-off while samples keep coming
        configure(DEBOUNCE_TICKS_RESET, THRESHOLD_STEP_RESET, THRESHOLD_MAX_RESET);
        configure(16'd1, 10'd10, 16'd10000);
        hold_request = 1'b1;
        run_phase(60, 0, 0);

        configure(16'hFFFF, 10'd1, 16'hFFFF);
        run_phase(40, 32, 32);
        configure(16'd4, 10'd100, 16'd2000);
        run_phase(300, 61, 61);

        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
